/* rtl/dmx2m_pkg.sv */
// ----------------------------------------------------------------------------
// dmx2m_pkg
// Shared types, constants and codes of the two-source merge tracker.
// ----------------------------------------------------------------------------
package dmx2m_pkg;

    localparam int NUM_PORTS  = 4;
    localparam int PORT_COUNT = 4;
    localparam int TIMEOUT_MS = 10000;
    localparam int MAX_SLOTS  = 512;

    localparam logic [NUM_PORTS-1:0] ALL_MASK = NUM_PORTS'((1 << PORT_COUNT) - 1);

    typedef enum logic [2:0] {
        REG_PORT0_ADDR = 3'd0,
        REG_PORT1_ADDR = 3'd1,
        REG_PORT2_ADDR = 3'd2,
        REG_PORT3_ADDR = 3'd3,
        REG_ENABLE     = 3'd4,
        REG_LTP        = 3'd5,
        REG_SYNC       = 3'd6,
        REG_NO_TIMEOUT = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ACT_SET_A   = 3'd0,
        ACT_SET_B   = 3'd1,
        ACT_MERGE_A = 3'd2,
        ACT_MERGE_B = 3'd3,
        ACT_DISCARD = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } fsm_state_t;

    typedef struct packed {
        logic [31:0] source_ip;
        logic [14:0] universe;
        logic [15:0] length;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0] port_index;
        action_t    action;
        logic       merge_ltp;
        logic       send_now;
        logic       start_output;
        logic [9:0] slots;
        logic       port_merging;
        logic       merge_active;
        logic       status_changed;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [NUM_PORTS-1:0][14:0] port_addr;
        logic [NUM_PORTS-1:0]       enable;
        logic [NUM_PORTS-1:0]       ltp;
        logic                       sync;
        logic                       no_timeout;
    } cfg_t;

    typedef struct packed {
        logic [31:0] a_ip;
        logic [31:0] b_ip;
        logic [31:0] a_time;
        logic [31:0] b_time;
    } src_entry_t;

    typedef struct packed {
        logic [NUM_PORTS-1:0] merging;
        logic [NUM_PORTS-1:0] transmitting;
        logic [NUM_PORTS-1:0] pending;
        logic                 merge_mode;
        logic                 changed;
    } trk_t;

endpackage

/* rtl/dmx2m_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dmx2m_cfg_regs
// Configuration register file: port addresses, masks and mode bits.
// ----------------------------------------------------------------------------
module dmx2m_cfg_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [2:0]           index,
    input  logic [14:0]          wdata,
    output dmx2m_pkg::cfg_t      cfg
);
    import dmx2m_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                cfg_reg.port_addr[i] <= 15'(i);
            end
            cfg_reg.enable     <= '0;
            cfg_reg.ltp        <= '0;
            cfg_reg.sync       <= 1'b0;
            cfg_reg.no_timeout <= 1'b0;
        end else if (wr_en) begin
            unique case (cfg_reg_t'(index))
                REG_PORT0_ADDR: cfg_reg.port_addr[0] <= wdata;
                REG_PORT1_ADDR: cfg_reg.port_addr[1] <= wdata;
                REG_PORT2_ADDR: cfg_reg.port_addr[2] <= wdata;
                REG_PORT3_ADDR: cfg_reg.port_addr[3] <= wdata;
                REG_ENABLE:     cfg_reg.enable       <= wdata[NUM_PORTS-1:0];
                REG_LTP:        cfg_reg.ltp          <= wdata[NUM_PORTS-1:0];
                REG_SYNC:       cfg_reg.sync         <= wdata[0];
                REG_NO_TIMEOUT: cfg_reg.no_timeout   <= wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/dmx2m_src_ram.sv */
// ----------------------------------------------------------------------------
// dmx2m_src_ram
// Per-port source slot memory, registered read, valid bit per
// entry so that an entry never written reads as zero.
// ----------------------------------------------------------------------------
module dmx2m_src_ram (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic [1:0]              rd_addr,
    output dmx2m_pkg::src_entry_t   rd_data,
    input  logic                    wr_en,
    input  logic [1:0]              wr_addr,
    input  dmx2m_pkg::src_entry_t   wr_data
);
    import dmx2m_pkg::*;

    src_entry_t           mem [NUM_PORTS];
    logic [NUM_PORTS-1:0] valid_reg;
    src_entry_t           rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* rtl/dmx2m_port_calc.sv */
// ----------------------------------------------------------------------------
// dmx2m_port_calc
// Per-port decision: source timeout, case selection, merge start and
// output/buffer choice, applied to one port's slots and the tracker flags.
// ----------------------------------------------------------------------------
module dmx2m_port_calc (
    input  logic [1:0]              port_sel,
    input  logic [31:0]             src_ip,
    input  logic [31:0]             now_ms,
    input  logic                    cfg_sync,
    input  logic                    cfg_no_timeout,
    input  dmx2m_pkg::src_entry_t   entry_in,
    input  dmx2m_pkg::trk_t         trk_in,
    output dmx2m_pkg::src_entry_t   entry_out,
    output dmx2m_pkg::trk_t         trk_out,
    output dmx2m_pkg::action_t      action,
    output logic                    send_now,
    output logic                    start_output
);
    import dmx2m_pkg::*;

    logic [NUM_PORTS-1:0] pbit;
    logic [31:0]          age_a;
    logic [31:0]          age_b;
    logic [31:0]          a;
    logic [31:0]          b;
    logic                 do_merge;

    assign pbit  = NUM_PORTS'(1) << port_sel;
    assign age_a = now_ms - entry_in.a_time;
    assign age_b = now_ms - entry_in.b_time;
    assign a     = entry_in.a_ip;
    assign b     = entry_in.b_ip;

    always_comb begin
        entry_out    = entry_in;
        trk_out      = trk_in;
        action       = ACT_DISCARD;
        do_merge     = 1'b0;
        send_now     = 1'b0;
        start_output = 1'b0;

        if (trk_in.merge_mode && !cfg_no_timeout) begin
            if (age_a > 32'(TIMEOUT_MS)) begin
                entry_out.a_ip  = '0;
                trk_out.merging = trk_out.merging & ~pbit;
            end
            if (age_b > 32'(TIMEOUT_MS)) begin
                entry_out.b_ip  = '0;
                trk_out.merging = trk_out.merging & ~pbit;
            end
            if ((trk_out.merging & ALL_MASK) == '0) begin
                trk_out.changed    = 1'b1;
                trk_out.merge_mode = 1'b0;
            end
        end

        // case selection uses slot IPs from before the timeout
        priority if (a == '0 && b == '0) begin
            entry_out.a_ip   = src_ip;
            entry_out.a_time = now_ms;
            action           = ACT_SET_A;
        end else if (a == src_ip && b == '0) begin
            entry_out.a_time = now_ms;
            action           = ACT_SET_A;
        end else if (a == '0 && b == src_ip) begin
            entry_out.b_time = now_ms;
            action           = ACT_SET_B;
        end else if (a != src_ip && b == '0) begin
            entry_out.b_ip   = src_ip;
            entry_out.b_time = now_ms;
            do_merge         = 1'b1;
            action           = ACT_MERGE_B;
        end else if (a == '0 && b != src_ip) begin
            entry_out.a_ip   = src_ip;
            entry_out.a_time = now_ms;
            do_merge         = 1'b1;
            action           = ACT_MERGE_A;
        end else if (a == src_ip && b != src_ip) begin
            entry_out.a_time = now_ms;
            do_merge         = 1'b1;
            action           = ACT_MERGE_A;
        end else if (a != src_ip && b == src_ip) begin
            entry_out.b_time = now_ms;
            do_merge         = 1'b1;
            action           = ACT_MERGE_B;
        end else begin
            action = ACT_DISCARD;
        end

        if (do_merge) begin
            if (!trk_out.merge_mode) begin
                trk_out.merge_mode = 1'b1;
                trk_out.changed    = 1'b1;
            end
            trk_out.merging = trk_out.merging | pbit;
        end

        if (action != ACT_DISCARD) begin
            if (cfg_sync && (trk_out.merging & pbit) == '0) begin
                trk_out.pending = trk_out.pending | pbit;
            end else begin
                send_now = 1'b1;
                if ((trk_out.transmitting & pbit) == '0) begin
                    start_output         = 1'b1;
                    trk_out.changed      = 1'b1;
                    trk_out.transmitting = trk_out.transmitting | pbit;
                end
            end
        end
    end

endmodule

/* rtl/dmx_two_source_merge_tracker.sv */
// ----------------------------------------------------------------------------
// dmx_two_source_merge_tracker
// Two-source merge tracker for DMX packet headers, one result per matching
// enabled output port.
// ----------------------------------------------------------------------------
// A packet header is taken when the block is idle. The sequencer then visits
// the ports one per cycle; a matching port adds an UPDATE state for the
// read-modify-write of its source slots in the port memory. Results are held
// until all ports are done, since the global merge mode and the status flag
// they carry are the values at the end of the packet, and are then sent one
// per cycle while the result side is ready; the port memory has a single
// read-modify-write path.
module dmx_two_source_merge_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [14:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dmx2m_pkg::in_item_t   s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output dmx2m_pkg::out_item_t  m_item
);
    import dmx2m_pkg::*;

    cfg_t        cfg;
    fsm_state_t  state_reg, state_next;
    in_item_t    item_reg;
    logic [1:0]  port_reg;
    trk_t        trk_reg;
    out_item_t   res_buf_reg [NUM_PORTS];
    logic [2:0]  res_cnt_reg;
    logic [1:0]  emit_idx_reg;
    logic        m_valid_reg;
    out_item_t   m_item_reg;

    src_entry_t  ram_rd_data;
    src_entry_t  ram_wr_data;
    trk_t        trk_next;
    action_t     calc_action;
    logic        calc_send;
    logic        calc_start;

    logic        port_match;
    logic        last_port;
    logic        emit_last;
    logic        out_free;
    logic        ram_rd_en;
    logic        ram_we;
    logic        buf_we;
    logic        out_load;
    logic        s_accept;
    logic [9:0]  slots;
    out_item_t   buf_entry;
    out_item_t   emit_entry;

    dmx2m_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wdata   (cfg_wdata),
        .cfg     (cfg)
    );

    dmx2m_src_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (ram_rd_en),
        .rd_addr (port_reg),
        .rd_data (ram_rd_data),
        .wr_en   (ram_we),
        .wr_addr (port_reg),
        .wr_data (ram_wr_data)
    );

    dmx2m_port_calc u_calc (
        .port_sel       (port_reg),
        .src_ip         (item_reg.source_ip),
        .now_ms         (item_reg.now_ms),
        .cfg_sync       (cfg.sync),
        .cfg_no_timeout (cfg.no_timeout),
        .entry_in       (ram_rd_data),
        .trk_in         (trk_reg),
        .entry_out      (ram_wr_data),
        .trk_out        (trk_next),
        .action         (calc_action),
        .send_now       (calc_send),
        .start_output   (calc_start)
    );

    assign port_match = cfg.enable[port_reg] && (cfg.port_addr[port_reg] == item_reg.universe);
    assign last_port  = (port_reg == 2'(PORT_COUNT - 1));
    assign emit_last  = (({1'b0, emit_idx_reg} + 3'd1) == res_cnt_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign slots      = (item_reg.length > 16'(MAX_SLOTS)) ? 10'(MAX_SLOTS)
                                                            : item_reg.length[9:0];

    always_comb begin
        buf_entry                = '0;
        buf_entry.port_index     = port_reg;
        buf_entry.action         = calc_action;
        buf_entry.merge_ltp      = cfg.ltp[port_reg];
        buf_entry.send_now       = calc_send;
        buf_entry.start_output   = calc_start;
        buf_entry.slots          = slots;
        buf_entry.port_merging   = trk_next.merging[port_reg];
    end

    always_comb begin
        emit_entry                = res_buf_reg[emit_idx_reg];
        emit_entry.merge_active   = trk_reg.merge_mode;
        emit_entry.status_changed = trk_reg.changed;
        emit_entry.last           = emit_last;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (port_match) begin
                    state_next = ST_UPDATE;
                end else if (last_port) begin
                    state_next = (res_cnt_reg == '0) ? ST_IDLE : ST_EMIT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_UPDATE: begin
                state_next = last_port ? ST_EMIT : ST_SCAN;
            end
            ST_EMIT: begin
                if (out_free && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        ram_rd_en = 1'b0;
        ram_we    = 1'b0;
        buf_we    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready   = 1'b1;
            ST_SCAN:   ram_rd_en = port_match;
            ST_UPDATE: begin
                ram_we = 1'b1;
                buf_we = 1'b1;
            end
            ST_EMIT:   out_load  = out_free;
            default: begin
            end
        endcase
    end

    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            port_reg     <= '0;
            trk_reg      <= '0;
            res_cnt_reg  <= '0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (s_accept) begin
                port_reg        <= '0;
                res_cnt_reg     <= '0;
                emit_idx_reg    <= '0;
                trk_reg.changed <= 1'b0;
            end

            if (state_reg == ST_SCAN && !port_match && !last_port) begin
                port_reg <= port_reg + 2'd1;
            end

            if (buf_we) begin
                trk_reg     <= trk_next;
                res_cnt_reg <= res_cnt_reg + 3'd1;
                if (!last_port) begin
                    port_reg <= port_reg + 2'd1;
                end
            end

            if (out_load) begin
                emit_idx_reg <= emit_idx_reg + 2'd1;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_item;
        end
        if (buf_we) begin
            res_buf_reg[res_cnt_reg[1:0]] <= buf_entry;
        end
        if (out_load) begin
            m_item_reg <= emit_entry;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_no_rd_wr_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_rd_en))
        else $error("port memory read and write in the same cycle");

    a_res_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= 3'(PORT_COUNT))
        else $error("result count exceeds port count");

    a_mode_needs_merging: assert property (@(posedge aclk) disable iff (!aresetn)
        trk_reg.merge_mode |-> ((trk_reg.merging & ALL_MASK) != '0))
        else $error("merge mode on with no merging port");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && emit_last) |=> (state_reg == ST_IDLE && m_valid && m_item.last))
        else $error("final result did not close the item");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the two-source merge tracker against a cycle-free predictor. Packet
// headers go in over a valid/ready channel and every port result is compared
// field by field with the oldest predicted one. A directed table covers reset
// state, field extremes, slot claims, merge entry, discards, stale sources
// and sync buffering. Random phases then run under several register settings
// with random idling on both sides and one long stall on the result side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dmx2m_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        int        seg;
        in_item_t  pkt;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = REG_PORT0_ADDR;
    logic [14:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_item    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_item;

    // predictor state
    cfg_t        live_cfg;
    logic [31:0] slot_a_ip   [NUM_PORTS];
    logic [31:0] slot_b_ip   [NUM_PORTS];
    logic [31:0] slot_a_time [NUM_PORTS];
    logic [31:0] slot_b_time [NUM_PORTS];
    logic [NUM_PORTS-1:0] merging      = '0;
    logic [NUM_PORTS-1:0] transmitting = '0;
    logic [NUM_PORTS-1:0] pending      = '0;
    logic                 merge_mode   = 1'b0;

    out_item_t   port_result_q [$];
    dir_row_t    dir_rows [$];
    logic [31:0] ip_pool [4];
    logic [31:0] pkt_clock = '0;

    int n_errors   = 0;
    int n_checked  = 0;
    int n_packets  = 0;
    int n_settings = 0;
    int n_merges   = 0;
    int n_discards = 0;
    int n_stale    = 0;

    dmx_two_source_merge_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic cfg_t make_cfg(input logic [14:0] a0, a1, a2, a3,
                                      input logic [3:0] en, ltp,
                                      input logic sync, nto);
        cfg_t c;
        c.port_addr[0] = a0;
        c.port_addr[1] = a1;
        c.port_addr[2] = a2;
        c.port_addr[3] = a3;
        c.enable       = en;
        c.ltp          = ltp;
        c.sync         = sync;
        c.no_timeout   = nto;
        return c;
    endfunction

    function automatic void add_row(input int seg, input logic [31:0] ip,
                                    input logic [14:0] uni, input logic [15:0] len,
                                    input logic [31:0] now, input logic typed = 1'b0,
                                    input out_item_t want = '0);
        dir_row_t row;
        row.seg            = seg;
        row.pkt.source_ip  = ip;
        row.pkt.universe   = uni;
        row.pkt.length     = len;
        row.pkt.now_ms     = now;
        row.typed          = typed;
        row.want           = want;
        dir_rows.push_back(row);
    endfunction

    function automatic int draw_gap(input int n);
        return (n % 64 < 16) ? 0 : int'($urandom_range(0, 13));
    endfunction

    // Per-port slot tracking for one packet; queues the port results it causes.
    function automatic void track_packet(input in_item_t pkt);
        out_item_t   res [$];
        out_item_t   r;
        logic [31:0] old_a, old_b, ip, age;
        logic [9:0]  slots;
        action_t     act;
        logic        send, start, chg;
        chg   = 1'b0;
        ip    = pkt.source_ip;
        slots = (pkt.length < 16'(MAX_SLOTS)) ? pkt.length[9:0] : 10'(MAX_SLOTS);
        for (int p = 0; p < PORT_COUNT; p++) begin
            if (!live_cfg.enable[p] || live_cfg.port_addr[p] != pkt.universe)
                continue;
            old_a = slot_a_ip[p];
            old_b = slot_b_ip[p];
            if (merge_mode && !live_cfg.no_timeout) begin
                age = pkt.now_ms - slot_a_time[p];
                if (age > 32'(TIMEOUT_MS)) begin
                    slot_a_ip[p] = '0;
                    merging[p]   = 1'b0;
                    n_stale++;
                end
                age = pkt.now_ms - slot_b_time[p];
                if (age > 32'(TIMEOUT_MS)) begin
                    slot_b_ip[p] = '0;
                    merging[p]   = 1'b0;
                    n_stale++;
                end
                if ((merging & ALL_MASK) == '0) begin
                    chg        = 1'b1;
                    merge_mode = 1'b0;
                end
            end
            // case selection uses the IPs from before the stale check
            if (old_a == '0 && old_b == '0) begin
                slot_a_ip[p]   = ip;
                slot_a_time[p] = pkt.now_ms;
                act            = ACT_SET_A;
            end else if (old_a == ip && old_b == '0) begin
                slot_a_time[p] = pkt.now_ms;
                act            = ACT_SET_A;
            end else if (old_a == '0 && old_b == ip) begin
                slot_b_time[p] = pkt.now_ms;
                act            = ACT_SET_B;
            end else if (old_a != ip && old_b == '0) begin
                slot_b_ip[p]   = ip;
                slot_b_time[p] = pkt.now_ms;
                act            = ACT_MERGE_B;
            end else if (old_a == '0 && old_b != ip) begin
                slot_a_ip[p]   = ip;
                slot_a_time[p] = pkt.now_ms;
                act            = ACT_MERGE_A;
            end else if (old_a == ip && old_b != ip) begin
                slot_a_time[p] = pkt.now_ms;
                act            = ACT_MERGE_A;
            end else if (old_a != ip && old_b == ip) begin
                slot_b_time[p] = pkt.now_ms;
                act            = ACT_MERGE_B;
            end else begin
                act = ACT_DISCARD;
            end
            if (act == ACT_MERGE_A || act == ACT_MERGE_B) begin
                if (!merge_mode) begin
                    merge_mode = 1'b1;
                    chg        = 1'b1;
                end
                merging[p] = 1'b1;
                n_merges++;
            end
            send  = 1'b0;
            start = 1'b0;
            if (act == ACT_DISCARD) begin
                n_discards++;
            end else if (live_cfg.sync && !merging[p]) begin
                pending[p] = 1'b1;
            end else begin
                send = 1'b1;
                if (!transmitting[p]) begin
                    start           = 1'b1;
                    chg             = 1'b1;
                    transmitting[p] = 1'b1;
                end
            end
            r              = '0;
            r.port_index   = 2'(p);
            r.action       = act;
            r.merge_ltp    = live_cfg.ltp[p];
            r.send_now     = send;
            r.start_output = start;
            r.slots        = slots;
            r.port_merging = merging[p];
            res.push_back(r);
        end
        foreach (res[k]) begin
            res[k].merge_active   = merge_mode;
            res[k].status_changed = chg;
            res[k].last           = (k == res.size() - 1);
            port_result_q.push_back(res[k]);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
            n_errors++;
        end
    endfunction

    task automatic offer_packet(input in_item_t pkt, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= pkt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic apply_cfg(input cfg_t c);
        cfg_reg_t    idx;
        logic [14:0] val;
        idx = idx.first();
        do begin
            case (idx)
                REG_ENABLE:     val = 15'(c.enable);
                REG_LTP:        val = 15'(c.ltp);
                REG_SYNC:       val = 15'(c.sync);
                REG_NO_TIMEOUT: val = 15'(c.no_timeout);
                default:        val = c.port_addr[2'(idx)];
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(posedge aclk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_wr_en <= 1'b0;
        live_cfg = c;
        n_settings++;
    endtask

    // wait for every port result, then let a trailing packet with no result finish
    task automatic settle();
        s_valid <= 1'b0;
        while (port_result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (port_result_q.size() == 0) begin
                $display("%0t: port result expected none actual %p", $time, m_item);
                n_errors++;
            end else begin
                want = port_result_q.pop_front();
                check_field("port_index", 32'(want.port_index), 32'(m_item.port_index));
                check_field("action", 32'(want.action), 32'(m_item.action));
                check_field("merge_ltp", 32'(want.merge_ltp), 32'(m_item.merge_ltp));
                check_field("send_now", 32'(want.send_now), 32'(m_item.send_now));
                check_field("start_output", 32'(want.start_output),
                            32'(m_item.start_output));
                check_field("slots", 32'(want.slots), 32'(m_item.slots));
                check_field("port_merging", 32'(want.port_merging),
                            32'(m_item.port_merging));
                check_field("merge_active", 32'(want.merge_active),
                            32'(m_item.merge_active));
                check_field("status_changed", 32'(want.status_changed),
                            32'(m_item.status_changed));
                check_field("last", 32'(want.last), 32'(m_item.last));
                n_checked++;
            end
        end
    end

    initial begin : result_sink
        int taken;
        int stall;
        taken = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken == HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = draw_gap(taken);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        dir_row_t    row;
        cfg_t        seg_cfg [4];
        cfg_t        phase_cfg [5];
        int          phase_items [5];
        int          cur_seg;
        int          roll;
        in_item_t    pkt;
        logic [14:0] ua, ub;

        live_cfg = make_cfg(15'd0, 15'd1, 15'd2, 15'd3, 4'b0000, 4'b0000, 1'b0, 1'b0);
        foreach (slot_a_ip[p]) begin
            slot_a_ip[p]   = '0;
            slot_b_ip[p]   = '0;
            slot_a_time[p] = '0;
            slot_b_time[p] = '0;
        end

        seg_cfg[0] = live_cfg;
        seg_cfg[1] = make_cfg(15'h0000, 15'h7fff, 15'h1234, 15'h1234,
                              4'b1111, 4'b0101, 1'b0, 1'b0);
        seg_cfg[2] = make_cfg(15'h2aaa, 15'h2aaa, 15'h2aaa, 15'h2aaa,
                              4'b1011, 4'b1111, 1'b1, 1'b1);
        seg_cfg[3] = make_cfg(15'h2aaa, 15'h2aaa, 15'h2aaa, 15'h2aaa,
                              4'b1111, 4'b0000, 1'b1, 1'b0);

        // reset settings: no port enabled
        add_row(0, 32'd1, 15'd0, 16'd8, 32'd0);
        // first claim, renewal, merge entry, merge renewal, third sender
        add_row(1, 32'd1, 15'd0, 16'd0, 32'd0, 1'b1,
                out_item_t'{2'd0, ACT_SET_A, 1'b1, 1'b1, 1'b1, 10'd0,
                            1'b0, 1'b0, 1'b1, 1'b1});
        add_row(1, 32'd1, 15'd0, 16'hffff, 32'd100, 1'b1,
                out_item_t'{2'd0, ACT_SET_A, 1'b1, 1'b1, 1'b0, 10'd512,
                            1'b0, 1'b0, 1'b0, 1'b1});
        add_row(1, 32'd2, 15'd0, 16'd512, 32'd200, 1'b1,
                out_item_t'{2'd0, ACT_MERGE_B, 1'b1, 1'b1, 1'b0, 10'd512,
                            1'b1, 1'b1, 1'b1, 1'b1});
        add_row(1, 32'd1, 15'd0, 16'd513, 32'd300, 1'b1,
                out_item_t'{2'd0, ACT_MERGE_A, 1'b1, 1'b1, 1'b0, 10'd512,
                            1'b1, 1'b1, 1'b0, 1'b1});
        add_row(1, 32'd3, 15'd0, 16'd1, 32'd400, 1'b1,
                out_item_t'{2'd0, ACT_DISCARD, 1'b1, 1'b0, 1'b0, 10'd1,
                            1'b1, 1'b1, 1'b0, 1'b1});
        add_row(1, 32'd5, 15'h4000, 16'd20, 32'd450);
        add_row(1, 32'hffff_ffff, 15'h1234, 16'd511, 32'd500);
        // IP zero claim leaves the slot free, then time wraps
        add_row(1, 32'd0, 15'h7fff, 16'd2, 32'hffff_fff0);
        add_row(1, 32'd7, 15'h7fff, 16'd3, 32'hffff_fff8);
        add_row(1, 32'd9, 15'h7fff, 16'd4, 32'd5);
        // both sources stale; renewal does not restore the cleared slot
        add_row(1, 32'd1, 15'd0, 16'd64, 32'd10401);
        add_row(1, 32'd1, 15'd0, 16'd65, 32'd10402);
        add_row(1, 32'd4, 15'h1234, 16'd100, 32'hffff_ffff);
        // sync buffering, no timeouts, shared universe
        add_row(2, 32'd10, 15'h2aaa, 16'd24, 32'd20000);
        add_row(2, 32'd11, 15'h2aaa, 16'd24, 32'd20001);
        add_row(2, 32'd10, 15'h2aaa, 16'd24, 32'd90000);
        add_row(2, 32'd12, 15'h2aaa, 16'd24, 32'd90001);
        // everything goes stale, merge mode drops, then buffering resumes
        add_row(3, 32'd11, 15'h2aaa, 16'd48, 32'h8000_0000);
        add_row(3, 32'd11, 15'h2aaa, 16'd48, 32'h8000_0001);
        add_row(3, 32'd12, 15'h2aaa, 16'd48, 32'h8000_0002);
        add_row(3, 32'd13, 15'h2aaa, 16'd48, 32'h8000_0003);
        add_row(3, 32'd14, 15'h5555, 16'h5555, 32'h8000_0004);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        cur_seg = 0;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.seg != cur_seg) begin
                settle();
                apply_cfg(seg_cfg[row.seg]);
                cur_seg = row.seg;
            end
            offer_packet(row.pkt, draw_gap(i));
            track_packet(row.pkt);
            if (row.typed) begin
                void'(port_result_q.pop_back());
                port_result_q.push_back(row.want);
            end
            n_packets++;
        end

        phase_cfg[0] = make_cfg(15'd0, 15'd0, 15'd0, 15'd0, 4'b0001, 4'b0000, 1'b0, 1'b0);
        phase_cfg[1] = make_cfg(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                                4'b1111, 4'($urandom), 1'b0, 1'b0);
        ua = 15'($urandom);
        phase_cfg[2] = make_cfg(ua, ua, ua, ua, 4'b1111, 4'($urandom), 1'b1, 1'b0);
        ua = 15'($urandom);
        ub = 15'($urandom);
        phase_cfg[3] = make_cfg(ua, ua, ub, ub, 4'b1101, 4'($urandom), 1'b0, 1'b1);
        phase_cfg[4] = make_cfg(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff,
                                4'b1111, 4'b1111, 1'b1, 1'b1);
        phase_items  = '{60, 80, 80, 80, 80};

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            apply_cfg(phase_cfg[ph]);
            ip_pool[0] = $urandom;
            ip_pool[1] = $urandom;
            ip_pool[2] = $urandom;
            ip_pool[3] = $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
            for (int k = 0; k < phase_items[ph]; k++) begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    pkt.length = '0;
                else if (roll == 1)
                    pkt.length = 16'(MAX_SLOTS);
                else if (roll == 2)
                    pkt.length = 16'hffff;
                else if (roll < 6)
                    pkt.length = 16'($urandom);
                else
                    pkt.length = 16'($urandom_range(0, 600));
                if ($urandom_range(0, 99) < 85) begin
                    // well-formed traffic: a few senders on configured universes
                    pkt.universe  = live_cfg.port_addr[$urandom_range(0, 3)];
                    pkt.source_ip = ip_pool[($urandom_range(0, 9) == 0) ? 3
                                            : $urandom_range(0, 2)];
                    roll = $urandom_range(0, 99);
                    if (roll < 80)
                        pkt_clock = pkt_clock + $urandom_range(0, 2500);
                    else if (roll < 92)
                        pkt_clock = pkt_clock + $urandom_range(TIMEOUT_MS + 1, 30000);
                    else
                        pkt_clock = $urandom;
                    pkt.now_ms = pkt_clock;
                end else begin
                    pkt.universe  = 15'($urandom);
                    pkt.source_ip = $urandom;
                    pkt.now_ms    = $urandom;
                end
                offer_packet(pkt, draw_gap(k));
                track_packet(pkt);
                n_packets++;
            end
        end
        settle();

        $display("run covered %0d packets under %0d register settings, %0d port results",
                 n_packets, n_settings, n_checked);
        $display("merge decisions %0d, discards %0d, stale sources dropped %0d",
                 n_merges, n_discards, n_stale);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dmx2m_pkg.sv
rtl/dmx2m_cfg_regs.sv
rtl/dmx2m_src_ram.sv
rtl/dmx2m_port_calc.sv
rtl/dmx_two_source_merge_tracker.sv
tb/testbench.sv
